@@ design/tsdl_pkg.sv @@
// Shared types and constants for the timestamped sample delay line.
// No dependencies; imported by every module of the block.
package tsdl_pkg;

  localparam int unsigned RingDepthDef = 64;
  localparam int unsigned TimeW        = 32;
  localparam int unsigned AxisW        = 16;
  localparam int unsigned DelayW       = 16;

  localparam logic [TimeW-1:0] MinGapMs = 32'd10;
  localparam logic [TimeW-1:0] MaxErrMs = 32'd1000;

  // ring entry: timestamp in the low bits, then x, y, z (same layout as s_axis tdata)
  typedef struct packed {
    logic signed [AxisW-1:0] z;
    logic signed [AxisW-1:0] y;
    logic signed [AxisW-1:0] x;
    logic        [TimeW-1:0] tstamp;
  } entry_t;

  typedef struct packed {
    logic signed [AxisW-1:0] z;
    logic signed [AxisW-1:0] y;
    logic signed [AxisW-1:0] x;
    logic                    hist;
  } res_t;

endpackage

@@ design/timestamped_sample_delay_line.sv @@
// Timestamped sample delay line, top level: config register, output register, ring and scan.
// Depends on tsdl_pkg, tsdl_ring and tsdl_ctrl.
//
//  channel  | direction | transaction when         | contents
//  s_axis   | in        | tvalid & tready          | time_ms, axis_x, axis_y, axis_z
//  m_axis   | out       | tvalid & tready          | out_x, out_y, out_z; tuser from_history
//  cfg      | in        | cfg_we_i                 | delay_ms
//
// A kept sample is written to the ring in the idle state; the scan then reads each ring
// entry in turn through the single memory read port and passes it through the difference
// and compare pipeline stages, then closes, and the result is handed off.
// A sample under 10 ms after the last kept one is dropped without a scan.
// Reset clears the ring through per-entry valid bits; no clearing pass.
// A waiting result sits in the output register; only a second finished result stalls.
module timestamped_sample_delay_line import tsdl_pkg::*; #(
  parameter int unsigned RING_DEPTH = RingDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // [31:0] time_ms, [47:32] axis_x, [63:48] axis_y, [79:64] axis_z
  input  logic [79:0]        s_axis_tdata_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // [15:0] out_x, [31:16] out_y, [47:32] out_z
  output logic [47:0]        m_axis_tdata_o,
  // [0] from_history
  output logic               m_axis_tuser_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  input  logic               cfg_we_i,
  input  logic [DelayW-1:0]  cfg_wdata_i
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);

  logic [DelayW-1:0] delay_q;
  logic              m_vld_q;
  res_t              m_res_q;

  entry_t            in_entry;
  logic              wr_en;
  logic [PtrW-1:0]   wr_addr;
  entry_t            wr_data;
  logic              rd_en;
  logic [PtrW-1:0]   rd_addr;
  entry_t            rd_data;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  assign in_entry.tstamp = s_axis_tdata_i[31:0];
  assign in_entry.x      = s_axis_tdata_i[47:32];
  assign in_entry.y      = s_axis_tdata_i[63:48];
  assign in_entry.z      = s_axis_tdata_i[79:64];

  assign res_ready = !m_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      m_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
      if (res_ready) begin
        m_vld_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {m_res_q.z, m_res_q.y, m_res_q.x};
  assign m_axis_tuser_o  = m_res_q.hist;

  tsdl_ring #(
    .RingDepth (RING_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  tsdl_ctrl #(
    .RingDepth (RING_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_entry_i  (in_entry),
    .delay_i     (delay_q),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

endmodule

@@ design/tsdl_ring.sv @@
// Sample ring: one synchronous memory of timestamp plus x/y/z, with a registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses tsdl_pkg.
module tsdl_ring import tsdl_pkg::*; #(
  parameter  int unsigned RingDepth = RingDepthDef,
  localparam int unsigned PtrW      = $clog2(RingDepth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [PtrW-1:0] wr_addr_i,
  input  entry_t          wr_data_i,
  input  logic            rd_en_i,
  input  logic [PtrW-1:0] rd_addr_i,
  output entry_t          rd_data_o
);

  entry_t                 mem [RingDepth];
  logic   [RingDepth-1:0] vld_q;
  entry_t                 rdata_q;
  logic                   rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

@@ design/tsdl_ctrl.sv @@
// Control and scan unit: gap check, ring write, nearest-timestamp scan, result hand-off.
// Drives the tsdl_ring ports; uses tsdl_pkg.
module tsdl_ctrl import tsdl_pkg::*; #(
  parameter  int unsigned RingDepth = RingDepthDef,
  localparam int unsigned PtrW      = $clog2(RingDepth)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  entry_t            in_entry_i,
  input  logic [DelayW-1:0] delay_i,
  output logic              wr_en_o,
  output logic [PtrW-1:0]   wr_addr_o,
  output entry_t            wr_data_o,
  output logic              rd_en_o,
  output logic [PtrW-1:0]   rd_addr_o,
  input  entry_t            rd_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  localparam logic [PtrW-1:0] LastIdx = PtrW'(RingDepth - 1);

  state_e                  state_q;
  logic [TimeW-1:0]        last_q;
  logic [PtrW-1:0]         wp_q;
  logic [PtrW-1:0]         iss_q;
  logic                    iss_done_q;
  logic                    p1_vld_q;
  logic                    p2_vld_q;
  logic [TimeW-1:0]        target_q;
  logic [TimeW-1:0]        best_dist_q;
  logic                    best_hit_q;
  logic [TimeW-1:0]        diff_q;
  entry_t                  p2_samp_q;
  entry_t                  cur_q;
  entry_t                  best_q;

  logic [TimeW-1:0]        gap;
  logic                    take;
  logic [TimeW-1:0]        mag;
  logic                    better;
  logic [PtrW-1:0]         wp_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign gap        = in_entry_i.tstamp - last_q;
  assign take       = in_valid_i && in_ready_o && (gap >= MinGapMs);
  assign wp_next    = (wp_q == LastIdx) ? '0 : wp_q + 1'b1;

  assign wr_en_o   = take;
  assign wr_addr_o = wp_q;
  assign wr_data_o = in_entry_i;

  assign rd_en_o   = (state_q == ST_SCAN) && !iss_done_q;
  assign rd_addr_o = iss_q;

  // wrapped signed difference to magnitude; the most negative value maps to 2^31
  assign mag    = diff_q[TimeW-1] ? (~diff_q + 1'b1) : diff_q;
  assign better = p2_vld_q && (mag < best_dist_q);

  assign res_valid_o = (state_q == ST_RESULT);
  always_comb begin
    res_o.hist = best_hit_q;
    if (best_hit_q) begin
      res_o.x = best_q.x;
      res_o.y = best_q.y;
      res_o.z = best_q.z;
    end else begin
      res_o.x = cur_q.x;
      res_o.y = cur_q.y;
      res_o.z = cur_q.z;
    end
  end

  // payload pipeline of the scan: memory output -> difference -> compare
  always_ff @(posedge clk_i) begin
    diff_q    <= target_q - rd_data_i.tstamp;
    p2_samp_q <= rd_data_i;
    if (take) begin
      cur_q    <= in_entry_i;
      target_q <= in_entry_i.tstamp - TimeW'(delay_i);
    end
    if (better) begin
      best_q <= p2_samp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= '0;
      wp_q        <= '0;
      iss_q       <= '0;
      iss_done_q  <= 1'b0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      best_dist_q <= MaxErrMs;
      best_hit_q  <= 1'b0;
    end else begin
      p1_vld_q <= rd_en_o;
      p2_vld_q <= p1_vld_q;
      if (better) begin
        best_dist_q <= mag;
        best_hit_q  <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (take) begin
            last_q      <= in_entry_i.tstamp;
            wp_q        <= wp_next;
            iss_q       <= '0;
            iss_done_q  <= 1'b0;
            best_dist_q <= MaxErrMs;
            best_hit_q  <= 1'b0;
            state_q     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!iss_done_q) begin
            iss_q <= iss_q + 1'b1;
            if (iss_q == LastIdx) begin
              iss_done_q <= 1'b1;
            end
          end else if (!p1_vld_q && !p2_vld_q) begin
            // last compare has been folded into best_*
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Testbench for timestamped_sample_delay_line: directed and random sample streams with
// random idling on both stream ports, results checked against an in-bench ring model.
// Depends on tsdl_pkg and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tsdl_pkg::*;

  localparam int unsigned Depth       = RingDepthDef;
  localparam int unsigned DrainCycles = Depth + 16;
  localparam int unsigned CycleLimit  = 1_200_000;
  localparam int unsigned PhaseItems  = 222;

  typedef struct packed {
    logic signed [AxisW-1:0] x;
    logic signed [AxisW-1:0] y;
    logic signed [AxisW-1:0] z;
    logic                    hist;
  } field_sample_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic [79:0]       s_tdata   = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [47:0]       m_tdata;
  logic              m_tuser;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [DelayW-1:0] cfg_wdata = '0;

  // no idling on either side while set
  bit steady = 1'b0;
  int unsigned stall_left = 0;
  int unsigned err_count = 0;

  // ring model
  logic [TimeW-1:0]  ring_time [Depth];
  logic [AxisW-1:0]  ring_x    [Depth];
  logic [AxisW-1:0]  ring_y    [Depth];
  logic [AxisW-1:0]  ring_z    [Depth];
  logic [TimeW-1:0]  last_kept;
  int unsigned       wr_slot;
  logic [DelayW-1:0] delay_ms;
  field_sample_t     expected_samples [$];

  timestamped_sample_delay_line i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timestamped_sample_delay_line: mismatch");
    $finish;
  end

  // Returns 0 for a dropped sample; otherwise stores it and gives the delayed pick.
  function automatic bit predict_delayed_sample(input logic [TimeW-1:0] now,
                                                input logic [AxisW-1:0] x, y, z,
                                                output field_sample_t res);
    logic [TimeW-1:0] target;
    logic [TimeW-1:0] span;
    logic [TimeW-1:0] best_dist;
    int unsigned      best_idx;
    res = '0;
    if ((now - last_kept) < MinGapMs) return 1'b0;
    last_kept          = now;
    ring_time[wr_slot] = now;
    ring_x[wr_slot]    = x;
    ring_y[wr_slot]    = y;
    ring_z[wr_slot]    = z;
    wr_slot            = (wr_slot + 1 == Depth) ? 0 : wr_slot + 1;
    target    = now - delay_ms;
    best_dist = MaxErrMs;
    best_idx  = 0;
    for (int i = 0; i < Depth; i++) begin
      // signed wrapped distance, magnitude only; first minimum wins
      span = target - ring_time[i];
      if (span[TimeW-1]) span = -span;
      if (span < best_dist) begin
        best_dist = span;
        best_idx  = i;
      end
    end
    if (best_dist < MaxErrMs) begin
      res = '{ring_x[best_idx], ring_y[best_idx], ring_z[best_idx], 1'b1};
    end else begin
      res = '{x, y, z, 1'b0};
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [AxisW-1:0] got,
                                 input logic [AxisW-1:0] want);
    err_count++;
    $display("%0t ns %s: got %h expected %h", $time, what, got, want);
  endtask

  task automatic send_sample(input logic [TimeW-1:0] now, input logic [AxisW-1:0] x, y, z,
                             output bit kept);
    field_sample_t res;
    if (!steady && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(80, 1)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x, now};
    do @(posedge clk_i); while (!s_tready);
    kept = predict_delayed_sample(now, x, y, z, res);
    if (kept) expected_samples.push_back(res);
  endtask

  // dropped samples give no result, so drain a full scan after the last one
  task automatic wait_block_idle();
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_delay(input logic [DelayW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    delay_ms = value;
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // gap rule right after reset, delay at its reset value
  task automatic test_early_after_reset();
    bit kept;
    send_sample(32'd0,  16'h0101, 16'h0202, 16'h0303, kept);
    send_sample(32'd9,  16'h1111, 16'h2222, 16'h3333, kept);
    send_sample(32'd10, 16'h4444, 16'h5555, 16'h6666, kept);
    send_sample(32'd19, 16'h7777, 16'h8888, 16'h9999, kept);
    send_sample(32'd20, 16'haaaa, 16'hbbbb, 16'hcccc, kept);
  endtask

  task automatic test_axis_extremes();
    bit kept;
    wait_block_idle();
    write_delay('0);
    send_sample(32'd40, 16'h7fff, 16'h8000, 16'h0000, kept);
    send_sample(32'd50, 16'h8000, 16'hffff, 16'h7fff, kept);
    send_sample(32'd60, 16'hffff, 16'h0000, 16'h8000, kept);
    send_sample(32'd70, 16'h0001, 16'h5555, 16'haaaa, kept);
  endtask

  // hits in the ring, a near miss inside the error window, and a fallback to current
  task automatic test_delay_lookup();
    bit kept;
    wait_block_idle();
    write_delay(16'd20);
    send_sample(32'd90, 16'h1234, 16'h5678, 16'h9abc, kept);
    wait_block_idle();
    write_delay(16'd1000);
    send_sample(32'd1080, 16'h0f0f, 16'hf0f0, 16'h00ff, kept);
    send_sample(32'd2500, 16'hff00, 16'h3c3c, 16'hc3c3, kept);
    send_sample(32'd5000, 16'h6969, 16'h9696, 16'h1e1e, kept);
  endtask

  // counter wrap, backward jump, and a distance of exactly half the time range
  task automatic test_time_wrap();
    bit kept;
    wait_block_idle();
    write_delay(16'hffff);
    send_sample(32'hffff_fff0, 16'h2468, 16'hace0, 16'h1357, kept);
    send_sample(32'h0000_0005, 16'h9bdf, 16'h8642, 16'h0246, kept);
    send_sample(32'h0000_0006, 16'h7531, 16'h0f1e, 16'he1f0, kept);
    send_sample(32'h8000_ffff, 16'h5a5a, 16'ha5a5, 16'h7e7e, kept);
    send_sample(32'h0000_1000, 16'h8181, 16'h4242, 16'h2424, kept);
    send_sample(32'h0001_0005, 16'h1818, 16'hdbdb, 16'hbdbd, kept);
  endtask

  // mostly a steady 100 Hz-like stream, with early, jumping and backward samples mixed in
  task automatic test_random_stream(input logic [DelayW-1:0] delay, input bit quiet);
    int unsigned      kept_count;
    int unsigned      roll;
    logic [TimeW-1:0] now;
    logic [AxisW-1:0] x, y, z;
    bit               kept;
    wait_block_idle();
    write_delay(delay);
    steady     = quiet;
    kept_count = 0;
    now        = last_kept;
    while (kept_count < PhaseItems) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        now = now + $urandom_range(9);
      end else if (roll < 11) begin
        now = $urandom();
      end else if (roll < 13) begin
        now = now - $urandom_range(2000);
      end else if (roll < 16) begin
        now = now + $urandom_range(3000, 500);
      end else begin
        now = now + $urandom_range(30, 10);
      end
      x = AxisW'($urandom());
      y = AxisW'($urandom());
      z = AxisW'($urandom());
      send_sample(now, x, y, z, kept);
      if (kept) kept_count++;
    end
    steady = 1'b0;
  endtask

  // receiver: short random stalls
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!steady && $urandom_range(99) < 2) begin
      stall_left <= $urandom_range(4);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    field_sample_t got;
    field_sample_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser};
      if (expected_samples.size() == 0) begin
        report_mismatch("result with nothing expected", got.x, '0);
      end else begin
        want = expected_samples.pop_front();
        if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
        if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
        if (got.z !== want.z) report_mismatch("out_z", got.z, want.z);
        if (got.hist !== want.hist) begin
          report_mismatch("from_history", AxisW'(got.hist), AxisW'(want.hist));
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < Depth; i++) begin
      ring_time[i] = '0;
      ring_x[i]    = '0;
      ring_y[i]    = '0;
      ring_z[i]    = '0;
    end
    last_kept = '0;
    wr_slot   = 0;
    delay_ms  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_early_after_reset();
    test_axis_extremes();
    test_delay_lookup();
    test_time_wrap();
    test_random_stream(16'd0, 1'b0);
    test_random_stream(16'hffff, 1'b0);
    test_random_stream(16'd160, 1'b1);
    test_random_stream(16'd640, 1'b0);
    test_random_stream(16'd999, 1'b0);
    test_random_stream(16'd1400, 1'b0);
    test_random_stream(DelayW'($urandom()), 1'b0);
    test_random_stream(16'd10, 1'b0);
    wait_block_idle();

    if (err_count == 0) begin
      $display("timestamped_sample_delay_line: match");
    end else begin
      $display("timestamped_sample_delay_line: mismatch");
    end
    $finish;
  end

endmodule
